// ===== rtl/insertion_sorter_macros.svh =====
// assertion helpers, sampled on i_clk, off while i_rst_n is low
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH

`define INSC_ASSERT_NOW(label, cond, expect_now, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (expect_now)) else $error(msg);

`define INSC_ASSERT_NEXT(label, cond, expect_next, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expect_next)) else $error(msg);

`endif

// ===== rtl/insc_pkg.sv =====
package insc_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;

    typedef struct packed {
        logic                     valid;
        logic                     gt;
        logic signed [DATA_W-1:0] value;
    } t_link;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_ctrl;

endpackage

// ===== rtl/insc_cell.sv =====
module insc_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  insc_pkg::t_ctrl                   i_ctrl,
    input  logic signed [insc_pkg::DATA_W-1:0] i_value,
    input  insc_pkg::t_link                   i_lo,
    input  insc_pkg::t_link                   i_up,
    output insc_pkg::t_link                   o_link
);

    logic                              r_valid;
    logic signed [insc_pkg::DATA_W-1:0] r_value;
    logic                              w_gt;

    assign w_gt = r_valid && (r_value > i_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_up.valid;
        end else if (i_ctrl.insert) begin
            r_valid <= r_valid | i_lo.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_value <= i_up.value;
        end else if (i_ctrl.insert) begin
            if (i_lo.gt) begin
                r_value <= i_lo.value;
            end else if (w_gt || !r_valid) begin
                r_value <= i_value;
            end
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.gt    = w_gt;
    assign o_link.value = r_value;

endmodule

// ===== rtl/insertion_sorter.sv =====
// Insert: one beat per cycle outside drain, compare and shift along the cell chain.
// After the last beat of a list is taken the block enters drain; the output register
// loads the first result once the output is free.
// Drain: the stored results at one per cycle (plus output stall); input stalls until the last
// result is loaded into the output register.
// Reset clears the cell valid bits, the state, the drop flag and the output valid.
`include "insertion_sorter_macros.svh"

module insertion_sorter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [insc_pkg::DATA_W-1:0] i_value,
    input  logic                              i_last_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [insc_pkg::DATA_W-1:0] o_sorted_value,
    output logic                              o_last_result,
    output logic                              o_overflow
);

    localparam logic ST_FILL  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    localparam int N = insc_pkg::MAX_ITEMS;

    logic                              r_state;
    logic                              r_drop;
    logic                              r_out_valid;
    logic signed [insc_pkg::DATA_W-1:0] r_out_value;
    logic                              r_out_last;
    logic                              r_out_ovf;

    insc_pkg::t_link link [N];
    insc_pkg::t_ctrl w_ctrl;
    logic [N-1:0]    w_valid;
    logic [N-1:0]    w_thermo_bad;
    logic            w_in_acc;
    logic            w_full;
    logic            w_out_free;
    logic            w_final;

    assign o_in_stall = (r_state == ST_DRAIN);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = w_valid[N-1];
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_ctrl.insert = w_in_acc && !w_full;
    assign w_ctrl.shift  = (r_state == ST_DRAIN) && w_out_free && w_valid[0];
    assign w_final       = w_ctrl.shift && !w_valid[1];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            insc_pkg::t_link w_lo;
            insc_pkg::t_link w_up;
            if (g == 0) begin : g_lo0
                assign w_lo = '{valid: 1'b1, gt: 1'b0, value: '0};
            end else begin : g_lon
                assign w_lo = link[g-1];
            end
            if (g == N - 1) begin : g_uptop
                assign w_up = '{valid: 1'b0, gt: 1'b0, value: '0};
            end else begin : g_upn
                assign w_up = link[g+1];
            end
            insc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_value (i_value),
                .i_lo    (w_lo),
                .i_up    (w_up),
                .o_link  (link[g])
            );
            assign w_valid[g] = link[g].valid;
        end
    endgenerate

    // valid cells must form a run starting at cell 0
    assign w_thermo_bad = (w_valid + {{(N-1){1'b0}}, 1'b1}) & w_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_drop  <= 1'b0;
        end else begin
            case (r_state)
                ST_FILL: begin
                    if (w_in_acc && w_full) begin
                        r_drop <= 1'b1;
                    end
                    if (w_in_acc && i_last_item) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_final) begin
                        r_state <= ST_FILL;
                        r_drop  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_FILL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.shift) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.shift) begin
            r_out_value <= link[0].value;
            r_out_last  <= !w_valid[1];
            r_out_ovf   <= r_drop;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_last_result  = r_out_last;
    assign o_overflow     = r_out_ovf;

    `INSC_ASSERT_NOW(a_thermo, 1'b1, w_thermo_bad == '0, "cell valid bits not contiguous")
    `INSC_ASSERT_NOW(a_hold, r_out_valid && i_out_stall, !w_ctrl.shift, "chain shifted over stalled beat")
    `INSC_ASSERT_NEXT(a_final, w_final, (r_state == ST_FILL) && !r_drop && (w_valid == '0), "drain did not empty chain")
    `INSC_ASSERT_NEXT(a_start, w_in_acc && i_last_item, w_valid[0], "drain entered with empty chain")

endmodule

// ===== dv/tb_insertion_sorter.sv =====
module tb_insertion_sorter;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [insc_pkg::DATA_W-1:0] value;
        logic                               last;
        logic                               ovf;
    } t_sorted_beat;

    class t_sort_scoreboard;
        logic signed [insc_pkg::DATA_W-1:0] ladder [insc_pkg::MAX_ITEMS];
        int                                 fill;
        bit                                 dropped;
        t_sorted_beat                       sorted_q [$];
        int                                 errors;

        function new();
            fill    = 0;
            dropped = 1'b0;
            errors  = 0;
        endfunction

        function void note_beat(logic signed [insc_pkg::DATA_W-1:0] v, logic last);
            int           pos;
            t_sorted_beat b;
            if (fill >= insc_pkg::MAX_ITEMS) begin
                dropped = 1'b1;
            end else begin
                pos = fill;
                while (pos > 0 && ladder[pos-1] > v) begin
                    ladder[pos] = ladder[pos-1];
                    pos--;
                end
                ladder[pos] = v;
                fill++;
            end
            if (last) begin
                for (int k = 0; k < fill; k++) begin
                    b.value = ladder[k];
                    b.last  = (k == fill - 1);
                    b.ovf   = dropped;
                    sorted_q.push_back(b);
                end
                fill    = 0;
                dropped = 1'b0;
            end
        endfunction

        function void check_result(t_sorted_beat got);
            t_sorted_beat want;
            if (sorted_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result value=%0d last=%0b ovf=%0b",
                         $time, got.value, got.last, got.ovf);
            end else begin
                want = sorted_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch exp value=%0d last=%0b ovf=%0b",
                             $time, want.value, want.last, want.ovf,
                             " got value=%0d last=%0b ovf=%0b",
                             got.value, got.last, got.ovf);
                end
            end
        endfunction

        function int pending();
            return sorted_q.size();
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic signed [insc_pkg::DATA_W-1:0] i_value;
    logic                               i_last_item;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic signed [insc_pkg::DATA_W-1:0] o_sorted_value;
    logic                               o_last_result;
    logic                               o_overflow;

    t_sort_scoreboard sb;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               hold_left;
    int               items_sent;
    int               cycles;

    insertion_sorter u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .i_last_item    (i_last_item),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sorted_value (o_sorted_value),
        .o_last_result  (o_last_result),
        .o_overflow     (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[insertion_sorter] ERROR");
        $finish;
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result('{o_sorted_value, o_last_result, o_overflow});
        end
    end

    function automatic logic signed [insc_pkg::DATA_W-1:0] pick_value();
        logic signed [insc_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = int'($urandom_range(0, 16)) - 8;
            1: begin
                case ($urandom_range(0, 5))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = 32'sh8000_0001;
                    3: v = 32'sh7FFF_FFFE;
                    4: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // drive at the falling edge, return at a falling edge once the beat is taken (later if an idle gap is drawn)
    task automatic send_beat(input logic signed [insc_pkg::DATA_W-1:0] v, input logic last);
        i_in_valid  <= 1'b1;
        i_value     <= v;
        i_last_item <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(v, last);
        items_sent++;
        @(negedge i_clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic send_list(input int len);
        for (int i = 0; i < len; i++) begin
            send_beat(pick_value(), i == len - 1);
        end
    endtask

    task automatic send_lists(input int budget);
        int stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            send_list(($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12));
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        sb            = new();
        send_idle_pct = 23;
        recv_idle_pct = 68;
        hold_left     = 0;
        items_sent    = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_value       = '0;
        i_last_item   = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_beat(32'sh7FFF_FFFF, 1'b0);
        send_beat(32'sh8000_0000, 1'b0);
        send_beat(0, 1'b0);
        send_beat(-1, 1'b0);
        send_beat(1, 1'b0);
        send_beat(0, 1'b0);
        send_beat(32'sh5555_5555, 1'b0);
        send_beat(32'shAAAA_AAAA, 1'b1);
        send_beat(-5, 1'b1);
        send_beat(3, 1'b0);
        send_beat(3, 1'b0);
        send_beat(-2, 1'b0);
        send_beat(3, 1'b0);
        send_beat(-2, 1'b1);
        for (int i = 4; i >= 0; i--) begin
            send_beat(i, i == 0);
        end

        send_lists(20);

        // hold off the output so the block backs up its input
        wait_drained();
        send_idle_pct = 0;
        hold_left     = 300;
        send_list(8);
        send_list(6);
        send_list(5);
        wait_drained();

        send_idle_pct = 68;
        recv_idle_pct = 23;
        send_list(insc_pkg::MAX_ITEMS + $urandom_range(1, 3));
        send_lists(12);

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_list(insc_pkg::MAX_ITEMS);
        send_lists(8);

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[insertion_sorter] OK");
        end else begin
            $display("[insertion_sorter] ERROR");
        end
        $finish;
    end
endmodule
